FILE: src/tlj_pkg.sv
// tlj_pkg: shared types and constants for the text line justifier
// payload structs, controller states, command and status bundles
// depends on nothing
package tlj_pkg;

    localparam int CFG_W = 5;
    localparam logic [CFG_W-1:0] CFG_RESET = 5'd20;
    localparam int CNT_W = 7;
    localparam logic [CNT_W-1:0] MAX_RESULTS = 7'd64;

    localparam logic [7:0] CH_HYPHEN  = 8'h2D;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_CR      = 8'h0D;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       end_of_text;
    } text_in_t;

    typedef struct packed {
        logic [7:0] out_char;
        logic       last_of_run;
        logic       text_done;
    } char_out_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_DECODE,
        S_CUT_CHECK,
        S_CUT_LINE,
        S_CUT_PIECE,
        S_CUT_HYPHEN,
        S_PLACE_START,
        S_PLACE_FIT,
        S_PLACE_SPACE,
        S_PLACE_COPY,
        S_FLUSH_START,
        S_FLUSH_NL,
        S_FLUSH_DIV,
        S_FLUSH_WALK,
        S_FLUSH_SPACE,
        S_END_CHECK,
        S_END_FLUSH,
        S_END_CLEAR,
        S_FINAL
    } state_t;

    typedef enum logic [2:0] {
        EM_NEWLINE,
        EM_HYPHEN,
        EM_SPACE,
        EM_WORD,
        EM_LINE
    } emit_sel_t;

    typedef struct packed {
        logic      latch_in;
        logic      append;
        logic      emit;
        emit_sel_t emit_sel;
        logic      set_emitted;
        logic      clr_emitted;
        logic      pop_word;
        logic      clr_word;
        logic      load_piece;
        logic      dec_piece;
        logic      flush_init;
        logic      div_step;
        logic      walk_adv;
        logic      load_sp;
        logic      dec_sp;
        logic      put_space;
        logic      put_word;
        logic      line_clear;
        logic      wc_inc;
        logic      finalize;
    } cmd_t;

    typedef struct packed {
        logic is_sep;
        logic end_flag;
        logic wl_zero;
        logic wl_gt_w;
        logic wc_zero;
        logic wc_gt1;
        logic fit_over;
        logic emitted;
        logic piece_zero;
        logic div_ge;
        logic walk_done;
        logic cur_is_space;
        logic sp_zero;
        logic pend_valid;
        logic can_emit;
        logic out_free;
    } status_t;

endpackage

FILE: src/tlj_datapath.sv
// tlj_datapath: word and line stores, counters, gap arithmetic, output staging
// depends on tlj_pkg
module tlj_datapath #(
    parameter int MAX_WIDTH = 20
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_valid,
    input  logic [tlj_pkg::CFG_W-1:0]        cfg_data,
    input  tlj_pkg::text_in_t                text_data,
    input  tlj_pkg::cmd_t                    cmd,
    output tlj_pkg::status_t                 status,
    output logic                             char_valid,
    input  logic                             char_ready,
    output tlj_pkg::char_out_t               char_data
);

    localparam int CW  = $clog2(MAX_WIDTH + 2);
    localparam int LIW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int WIW = $clog2(MAX_WIDTH + 1);
    localparam logic [tlj_pkg::CFG_W-1:0] MAX_W5 = tlj_pkg::CFG_W'(MAX_WIDTH);
    localparam logic [CW-1:0] MAX_CW = CW'(MAX_WIDTH);
    localparam logic [CW-1:0] WMAX_CW = CW'(MAX_WIDTH + 1);

    logic [tlj_pkg::CFG_W-1:0] width_reg;
    logic [7:0]                byte_reg;
    logic                      end_reg;
    logic [7:0]                word_mem [MAX_WIDTH+1];
    logic [7:0]                line_mem [MAX_WIDTH];
    logic [CW-1:0]             wl_reg;
    logic [CW-1:0]             ll_reg;
    logic [CW-1:0]             wc_reg;
    logic                      emitted_reg;
    logic [CW-1:0]             piece_reg;
    logic [CW-1:0]             idx_reg;
    logic [CW-1:0]             rem_reg;
    logic [CW-1:0]             base_reg;
    logic [CW-1:0]             sp_reg;
    logic [tlj_pkg::CNT_W-1:0] cnt_reg;
    logic                      pend_valid_reg;
    logic [7:0]                pend_char_reg;
    logic                      out_valid_reg;
    tlj_pkg::char_out_t        out_reg;

    logic [tlj_pkg::CFG_W-1:0] w5;
    logic [CW-1:0]             weff;
    logic [CW-1:0]             gaps;
    logic [CW-1:0]             letters;
    logic [CW-1:0]             total;
    logic [CW:0]               fit_sum;
    logic [7:0]                line_cur;
    logic [7:0]                emit_char;
    logic                      out_free;
    logic                      emit_live;

    // effective width, clamped into two to max
    always_comb
    begin
        if (width_reg < 5'd2)
            w5 = 5'd2;
        else if (width_reg > MAX_W5)
            w5 = MAX_W5;
        else
            w5 = width_reg;
        weff = CW'(w5);
    end

    assign gaps    = wc_reg - CW'(1);
    assign letters = ll_reg - gaps;

    always_comb
    begin
        total = (weff > letters) ? (weff - letters) : '0;
        if (total < gaps)
            total = gaps;
    end

    assign fit_sum  = {1'b0, ll_reg} + {1'b0, wl_reg} + (CW+1)'(1);
    assign line_cur = line_mem[idx_reg[LIW-1:0]];

    always_comb
    begin
        case (cmd.emit_sel)
            tlj_pkg::EM_NEWLINE: emit_char = tlj_pkg::CH_NEWLINE;
            tlj_pkg::EM_HYPHEN:  emit_char = tlj_pkg::CH_HYPHEN;
            tlj_pkg::EM_SPACE:   emit_char = tlj_pkg::CH_SPACE;
            tlj_pkg::EM_WORD:    emit_char = word_mem[0];
            tlj_pkg::EM_LINE:    emit_char = line_cur;
            default:             emit_char = tlj_pkg::CH_SPACE;
        endcase
    end

    assign out_free  = !out_valid_reg || char_ready;
    assign emit_live = cmd.emit && (cnt_reg < tlj_pkg::MAX_RESULTS);

    always_comb
    begin
        status.is_sep       = (byte_reg == tlj_pkg::CH_SPACE) || (byte_reg == tlj_pkg::CH_TAB)
                           || (byte_reg == tlj_pkg::CH_NEWLINE) || (byte_reg == tlj_pkg::CH_CR);
        status.end_flag     = end_reg;
        status.wl_zero      = (wl_reg == '0);
        status.wl_gt_w      = (wl_reg > weff);
        status.wc_zero      = (wc_reg == '0);
        status.wc_gt1       = (wc_reg > CW'(1));
        status.fit_over     = (fit_sum > {1'b0, weff});
        status.emitted      = emitted_reg;
        status.piece_zero   = (piece_reg == '0);
        status.div_ge       = (rem_reg >= gaps);
        status.walk_done    = (idx_reg >= ll_reg) || (idx_reg >= MAX_CW);
        status.cur_is_space = (line_cur == tlj_pkg::CH_SPACE);
        status.sp_zero      = (sp_reg == '0);
        status.pend_valid   = pend_valid_reg;
        status.can_emit     = (cnt_reg >= tlj_pkg::MAX_RESULTS) || !pend_valid_reg || out_free;
        status.out_free     = out_free;
    end

    // control and counter registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg      <= tlj_pkg::CFG_RESET;
            wl_reg         <= '0;
            ll_reg         <= '0;
            wc_reg         <= '0;
            emitted_reg    <= 1'b0;
            cnt_reg        <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
                width_reg <= cfg_data;
            if (cmd.latch_in)
                cnt_reg <= '0;
            else if (emit_live)
                cnt_reg <= cnt_reg + tlj_pkg::CNT_W'(1);

            if (cmd.append && (wl_reg < WMAX_CW))
                wl_reg <= wl_reg + CW'(1);
            else if (cmd.pop_word)
                wl_reg <= wl_reg - CW'(1);
            else if (cmd.clr_word)
                wl_reg <= '0;

            if (cmd.line_clear)
            begin
                ll_reg <= '0;
                wc_reg <= '0;
            end
            else
            begin
                if ((cmd.put_space || cmd.put_word) && (ll_reg < MAX_CW))
                    ll_reg <= ll_reg + CW'(1);
                if (cmd.wc_inc)
                    wc_reg <= wc_reg + CW'(1);
            end

            if (cmd.set_emitted)
                emitted_reg <= 1'b1;
            else if (cmd.clr_emitted)
                emitted_reg <= 1'b0;

            if (out_valid_reg && char_ready)
                out_valid_reg <= 1'b0;
            if (emit_live)
            begin
                pend_valid_reg <= 1'b1;
                if (pend_valid_reg)
                    out_valid_reg <= 1'b1;
            end
            else if (cmd.finalize)
            begin
                pend_valid_reg <= 1'b0;
                out_valid_reg  <= 1'b1;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.latch_in)
        begin
            byte_reg <= text_data.text_byte;
            end_reg  <= text_data.end_of_text;
        end
        if (cmd.load_piece)
            piece_reg <= weff - CW'(1);
        else if (cmd.dec_piece)
            piece_reg <= piece_reg - CW'(1);

        if (cmd.flush_init)
        begin
            idx_reg  <= '0;
            rem_reg  <= total;
            base_reg <= '0;
        end
        else
        begin
            if (cmd.walk_adv)
                idx_reg <= idx_reg + CW'(1);
            if (cmd.div_step)
            begin
                rem_reg  <= rem_reg - gaps;
                base_reg <= base_reg + CW'(1);
            end
            else if (cmd.load_sp && (rem_reg != '0))
                rem_reg <= rem_reg - CW'(1);
        end

        if (cmd.load_sp)
            sp_reg <= base_reg + ((rem_reg != '0) ? CW'(1) : CW'(0));
        else if (cmd.dec_sp)
            sp_reg <= sp_reg - CW'(1);

        if (emit_live)
        begin
            pend_char_reg <= emit_char;
            if (pend_valid_reg)
            begin
                out_reg.out_char    <= pend_char_reg;
                out_reg.last_of_run <= 1'b0;
                out_reg.text_done   <= 1'b0;
            end
        end
        else if (cmd.finalize)
        begin
            out_reg.out_char    <= pend_char_reg;
            out_reg.last_of_run <= 1'b1;
            out_reg.text_done   <= end_reg;
        end
    end

    // word store: append at the tail, pop from the front
    always_ff @(posedge clk)
    begin
        if (cmd.append && (wl_reg < WMAX_CW))
            word_mem[wl_reg[WIW-1:0]] <= byte_reg;
        else if (cmd.pop_word)
        begin
            for (int j = 0; j < MAX_WIDTH; j++)
                word_mem[j] <= word_mem[j+1];
        end
    end

    // line store: words joined by single spaces
    always_ff @(posedge clk)
    begin
        if ((cmd.put_space || cmd.put_word) && (ll_reg < MAX_CW))
            line_mem[ll_reg[LIW-1:0]] <= cmd.put_space ? tlj_pkg::CH_SPACE : word_mem[0];
    end

    assign char_valid = out_valid_reg;
    assign char_data  = out_reg;

endmodule

FILE: src/tlj_ctrl.sv
// tlj_ctrl: sequencer for word placement, long-word cuts and line flushes
// depends on tlj_pkg
module tlj_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              text_valid,
    output logic              text_ready,
    input  tlj_pkg::status_t  status,
    output tlj_pkg::cmd_t     cmd
);

    tlj_pkg::state_t state_reg, state_next;
    tlj_pkg::state_t ret_reg, ret_next;
    logic            in_place_reg, in_place_next;
    logic            end_phase_reg, end_phase_next;
    logic            justify;
    tlj_pkg::state_t place_ret;

    assign justify   = (ret_reg != tlj_pkg::S_END_CLEAR) && status.wc_gt1;
    assign place_ret = end_phase_reg ? tlj_pkg::S_END_FLUSH : tlj_pkg::S_END_CHECK;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= tlj_pkg::S_IDLE;
            ret_reg       <= tlj_pkg::S_IDLE;
            in_place_reg  <= 1'b0;
            end_phase_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ret_reg       <= ret_next;
            in_place_reg  <= in_place_next;
            end_phase_reg <= end_phase_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        ret_next       = ret_reg;
        in_place_next  = in_place_reg;
        end_phase_next = end_phase_reg;
        cmd            = '0;
        cmd.emit_sel   = tlj_pkg::EM_SPACE;
        text_ready     = 1'b0;
        case (state_reg)
            tlj_pkg::S_IDLE:
            begin
                text_ready = 1'b1;
                if (text_valid)
                begin
                    cmd.latch_in = 1'b1;
                    state_next   = tlj_pkg::S_DECODE;
                end
            end
            tlj_pkg::S_DECODE:
            begin
                end_phase_next = 1'b0;
                if (status.is_sep)
                    state_next = tlj_pkg::S_PLACE_START;
                else
                begin
                    cmd.append    = 1'b1;
                    in_place_next = 1'b0;
                    state_next    = tlj_pkg::S_CUT_CHECK;
                end
            end
            tlj_pkg::S_CUT_CHECK:
            begin
                if (status.wl_gt_w)
                begin
                    ret_next   = tlj_pkg::S_CUT_LINE;
                    state_next = tlj_pkg::S_FLUSH_START;
                end
                else
                    state_next = in_place_reg ? tlj_pkg::S_PLACE_FIT : tlj_pkg::S_END_CHECK;
            end
            tlj_pkg::S_CUT_LINE:
            begin
                if (!status.emitted || status.can_emit)
                begin
                    cmd.emit        = status.emitted;
                    cmd.emit_sel    = tlj_pkg::EM_NEWLINE;
                    cmd.set_emitted = 1'b1;
                    cmd.load_piece  = 1'b1;
                    state_next      = tlj_pkg::S_CUT_PIECE;
                end
            end
            tlj_pkg::S_CUT_PIECE:
            begin
                if (status.piece_zero)
                    state_next = tlj_pkg::S_CUT_HYPHEN;
                else if (status.can_emit)
                begin
                    cmd.emit      = 1'b1;
                    cmd.emit_sel  = tlj_pkg::EM_WORD;
                    cmd.pop_word  = 1'b1;
                    cmd.dec_piece = 1'b1;
                end
            end
            tlj_pkg::S_CUT_HYPHEN:
            begin
                if (status.can_emit)
                begin
                    cmd.emit     = 1'b1;
                    cmd.emit_sel = tlj_pkg::EM_HYPHEN;
                    state_next   = tlj_pkg::S_CUT_CHECK;
                end
            end
            tlj_pkg::S_PLACE_START:
            begin
                if (status.wl_zero)
                    state_next = place_ret;
                else
                begin
                    in_place_next = 1'b1;
                    state_next    = tlj_pkg::S_CUT_CHECK;
                end
            end
            tlj_pkg::S_PLACE_FIT:
            begin
                if (!status.wc_zero && status.fit_over)
                begin
                    ret_next   = tlj_pkg::S_PLACE_SPACE;
                    state_next = tlj_pkg::S_FLUSH_START;
                end
                else
                    state_next = tlj_pkg::S_PLACE_SPACE;
            end
            tlj_pkg::S_PLACE_SPACE:
            begin
                cmd.put_space = !status.wc_zero;
                state_next    = tlj_pkg::S_PLACE_COPY;
            end
            tlj_pkg::S_PLACE_COPY:
            begin
                if (status.wl_zero)
                begin
                    cmd.wc_inc = 1'b1;
                    state_next = place_ret;
                end
                else
                begin
                    cmd.put_word = 1'b1;
                    cmd.pop_word = 1'b1;
                end
            end
            tlj_pkg::S_FLUSH_START:
            begin
                if (status.wc_zero)
                    state_next = ret_reg;
                else
                    state_next = tlj_pkg::S_FLUSH_NL;
            end
            tlj_pkg::S_FLUSH_NL:
            begin
                if (!status.emitted || status.can_emit)
                begin
                    cmd.emit        = status.emitted;
                    cmd.emit_sel    = tlj_pkg::EM_NEWLINE;
                    cmd.set_emitted = 1'b1;
                    cmd.flush_init  = 1'b1;
                    state_next      = justify ? tlj_pkg::S_FLUSH_DIV : tlj_pkg::S_FLUSH_WALK;
                end
            end
            tlj_pkg::S_FLUSH_DIV:
            begin
                if (status.div_ge)
                    cmd.div_step = 1'b1;
                else
                    state_next = tlj_pkg::S_FLUSH_WALK;
            end
            tlj_pkg::S_FLUSH_WALK:
            begin
                if (status.walk_done)
                begin
                    cmd.line_clear = 1'b1;
                    state_next     = ret_reg;
                end
                else if (justify && status.cur_is_space)
                begin
                    cmd.load_sp = 1'b1;
                    state_next  = tlj_pkg::S_FLUSH_SPACE;
                end
                else if (status.can_emit)
                begin
                    cmd.emit     = 1'b1;
                    cmd.emit_sel = tlj_pkg::EM_LINE;
                    cmd.walk_adv = 1'b1;
                end
            end
            tlj_pkg::S_FLUSH_SPACE:
            begin
                if (status.sp_zero)
                begin
                    cmd.walk_adv = 1'b1;
                    state_next   = tlj_pkg::S_FLUSH_WALK;
                end
                else if (status.can_emit)
                begin
                    cmd.emit     = 1'b1;
                    cmd.emit_sel = tlj_pkg::EM_SPACE;
                    cmd.dec_sp   = 1'b1;
                end
            end
            tlj_pkg::S_END_CHECK:
            begin
                if (status.end_flag)
                begin
                    end_phase_next = 1'b1;
                    state_next     = tlj_pkg::S_PLACE_START;
                end
                else
                    state_next = tlj_pkg::S_FINAL;
            end
            tlj_pkg::S_END_FLUSH:
            begin
                ret_next   = tlj_pkg::S_END_CLEAR;
                state_next = tlj_pkg::S_FLUSH_START;
            end
            tlj_pkg::S_END_CLEAR:
            begin
                cmd.clr_emitted = 1'b1;
                cmd.clr_word    = 1'b1;
                state_next      = tlj_pkg::S_FINAL;
            end
            tlj_pkg::S_FINAL:
            begin
                if (!status.pend_valid)
                    state_next = tlj_pkg::S_IDLE;
                else if (status.out_free)
                begin
                    cmd.finalize = 1'b1;
                    state_next   = tlj_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = tlj_pkg::S_IDLE;
            end
        endcase
    end

endmodule

FILE: src/text_line_justifier.sv
// text_line_justifier: greedy line packing with justification and hyphenation
// a plain letter byte passes through idle, decode, cut check, end check and final before the next is taken
// a byte that closes a line also walks each line column or space and each division step
// throughput: one byte at a time, set by the sequencer walking the line and word stores
// reset: rst_n asynchronous active low clears the control counters and flags, width returns to 20
// depends on tlj_pkg, tlj_ctrl, tlj_datapath
module text_line_justifier #(
    parameter int MAX_WIDTH = 20
) (
    input  logic                       clk,
    input  logic                       rst_n,
    // text input, one byte per transaction
    input  logic                       text_valid,
    output logic                       text_ready,
    input  tlj_pkg::text_in_t          text_data,
    // formatted characters out
    output logic                       char_valid,
    input  logic                       char_ready,
    output tlj_pkg::char_out_t         char_data,
    // line width register write
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [tlj_pkg::CFG_W-1:0]  cfg_data
);

    tlj_pkg::cmd_t    cmd;
    tlj_pkg::status_t status;

    // width writes must arrive only while idle; the block does not enforce it and always takes them
    assign cfg_ready = 1'b1;

    // sequencer: decides which store to walk and when to emit
    tlj_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .text_valid (text_valid),
        .text_ready (text_ready),
        .status     (status),
        .cmd        (cmd)
    );

    // stores, counters and a pending/output pair that marks the last character
    tlj_datapath #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_data   (cfg_data),
        .text_data  (text_data),
        .cmd        (cmd),
        .status     (status),
        .char_valid (char_valid),
        .char_ready (char_ready),
        .char_data  (char_data)
    );

endmodule

FILE: tb/tb.sv
// tb: self-checking testbench for text_line_justifier
// holds a scoreboard class with its own line packer and justifier, and the drivers
// depends on tlj_pkg and text_line_justifier
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LINE_MAX = 20;
    localparam int DRAIN_CYCLES = 200;

    // scoreboard: packs words into lines itself and keeps the characters still due
    class justify_scoreboard;
        logic [4:0] width_reg;
        byte unsigned line_buf[LINE_MAX];
        int unsigned line_len;
        int unsigned word_cnt;
        byte unsigned word_buf[LINE_MAX + 1];
        int unsigned word_len;
        bit had_line;
        tlj_pkg::char_out_t run_chars[$];
        tlj_pkg::char_out_t due_chars[$];
        int unsigned fail_count;

        function void clear_text();
            line_len = 0;
            word_cnt = 0;
            word_len = 0;
            had_line = 0;
        endfunction

        function void hard_reset();
            width_reg = tlj_pkg::CFG_RESET;
            clear_text();
            due_chars.delete();
            fail_count = 0;
        endfunction

        function void set_width(logic [4:0] w);
            width_reg = w;
        endfunction

        function int unsigned usable_width();
            if (width_reg < 2)
                return 2;
            if (width_reg > LINE_MAX)
                return LINE_MAX;
            return width_reg;
        endfunction

        function bit is_gap_char(byte unsigned b);
            return b == tlj_pkg::CH_SPACE || b == tlj_pkg::CH_TAB
                || b == tlj_pkg::CH_NEWLINE || b == tlj_pkg::CH_CR;
        endfunction

        function void put_char(byte unsigned ch);
            tlj_pkg::char_out_t c;
            if (run_chars.size() >= tlj_pkg::MAX_RESULTS)
                return;
            c.out_char = ch;
            c.last_of_run = 1'b0;
            c.text_done = 1'b0;
            run_chars.push_back(c);
        endfunction

        // newline goes between lines, never before the first one
        function void open_line();
            if (had_line)
                put_char(tlj_pkg::CH_NEWLINE);
            had_line = 1;
        endfunction

        function void close_line(bit spread);
            int unsigned gaps, letters, w, total, base, extra, sp;
            if (word_cnt == 0)
                return;
            open_line();
            if (spread && word_cnt > 1) begin
                gaps = word_cnt - 1;
                letters = line_len - gaps;
                w = usable_width();
                total = (w > letters) ? w - letters : 0;
                if (total < gaps)
                    total = gaps;
                base = total / gaps;
                extra = total % gaps;
                // leftmost gaps take the remainder
                for (int i = 0; i < line_len; i++) begin
                    if (line_buf[i] == tlj_pkg::CH_SPACE) begin
                        sp = base + (extra > 0 ? 1 : 0);
                        if (extra > 0)
                            extra--;
                        for (int k = 0; k < sp; k++)
                            put_char(tlj_pkg::CH_SPACE);
                    end
                    else begin
                        put_char(line_buf[i]);
                    end
                end
            end
            else begin
                for (int i = 0; i < line_len; i++)
                    put_char(line_buf[i]);
            end
            line_len = 0;
            word_cnt = 0;
        endfunction

        // a word wider than the line is cut into width-1 letters plus hyphen
        function void split_word();
            int unsigned w, piece;
            w = usable_width();
            while (word_len > w) begin
                piece = w - 1;
                close_line(1);
                open_line();
                for (int i = 0; i < piece; i++)
                    put_char(word_buf[i]);
                put_char(tlj_pkg::CH_HYPHEN);
                for (int i = 0; i < word_len - piece; i++)
                    word_buf[i] = word_buf[i + piece];
                word_len -= piece;
            end
        endfunction

        function void settle_word();
            int unsigned w;
            if (word_len == 0)
                return;
            split_word();
            w = usable_width();
            if (word_cnt > 0 && line_len + 1 + word_len > w)
                close_line(1);
            if (word_cnt > 0 && line_len < LINE_MAX) begin
                line_buf[line_len] = tlj_pkg::CH_SPACE;
                line_len++;
            end
            for (int i = 0; i < word_len && line_len < LINE_MAX; i++) begin
                line_buf[line_len] = word_buf[i];
                line_len++;
            end
            word_cnt++;
            word_len = 0;
        endfunction

        function void note_text(tlj_pkg::text_in_t t);
            run_chars.delete();
            if (is_gap_char(t.text_byte)) begin
                settle_word();
            end
            else begin
                if (word_len < LINE_MAX + 1) begin
                    word_buf[word_len] = t.text_byte;
                    word_len++;
                end
                split_word();
            end
            if (t.end_of_text) begin
                settle_word();
                close_line(0);
                had_line = 0;
                word_len = 0;
            end
            if (run_chars.size() > 0) begin
                run_chars[run_chars.size() - 1].last_of_run = 1'b1;
                if (t.end_of_text)
                    run_chars[run_chars.size() - 1].text_done = 1'b1;
            end
            foreach (run_chars[i])
                due_chars.push_back(run_chars[i]);
        endfunction

        function void check_char(tlj_pkg::char_out_t got);
            tlj_pkg::char_out_t want;
            if (due_chars.size() == 0) begin
                $error("unexpected character 0x%02h with nothing pending", got.out_char);
                fail_count++;
                return;
            end
            want = due_chars.pop_front();
            if (got.out_char !== want.out_char) begin
                $error("out_char expected 0x%02h actual 0x%02h", want.out_char, got.out_char);
                fail_count++;
            end
            if (got.last_of_run !== want.last_of_run) begin
                $error("last_of_run expected %0b actual %0b", want.last_of_run, got.last_of_run);
                fail_count++;
            end
            if (got.text_done !== want.text_done) begin
                $error("text_done expected %0b actual %0b", want.text_done, got.text_done);
                fail_count++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic text_valid;
    logic text_ready;
    tlj_pkg::text_in_t text_data;
    logic char_valid;
    logic char_ready;
    tlj_pkg::char_out_t char_data;
    logic cfg_valid;
    logic cfg_ready;
    logic [tlj_pkg::CFG_W-1:0] cfg_data;

    justify_scoreboard sb;
    bit calm;            // no idling on either side while set
    int unsigned rand_items;

    text_line_justifier uut (
        .clk(clk),
        .rst_n(rst_n),
        .text_valid(text_valid),
        .text_ready(text_ready),
        .text_data(text_data),
        .char_valid(char_valid),
        .char_ready(char_ready),
        .char_data(char_data),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data(cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // output side: random back-pressure, every completed transaction is checked
    always @(posedge clk)
    begin
        if (rst_n) begin
            if (char_valid && char_ready)
                sb.check_char(char_data);
            char_ready <= calm ? 1'b1 : ($urandom_range(0, 99) >= 15);
        end
    end

    // one byte transaction; valid stays up after acceptance unless a gap follows
    task automatic send_byte(input byte unsigned b, input bit last);
        tlj_pkg::text_in_t t;
        t.text_byte = b;
        t.end_of_text = last;
        if (!calm && $urandom_range(0, 99) < 15) begin
            text_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        text_valid <= 1'b1;
        text_data <= t;
        @(posedge clk);
        while (!text_ready)
            @(posedge clk);
        sb.note_text(t);
    endtask

    task automatic idle_input();
        text_valid <= 1'b0;
        @(posedge clk);
    endtask

    // block is idle once nothing is pending and a byte with no output has settled
    task automatic drain();
        idle_input();
        while (sb.due_chars.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_width(input logic [tlj_pkg::CFG_W-1:0] w);
        drain();
        cfg_valid <= 1'b1;
        cfg_data <= w;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        sb.set_width(w);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    function automatic byte unsigned pick_letter();
        byte unsigned b;
        do
            b = 8'($urandom_range(0, 255));
        while (b == tlj_pkg::CH_SPACE || b == tlj_pkg::CH_TAB
               || b == tlj_pkg::CH_NEWLINE || b == tlj_pkg::CH_CR);
        return b;
    endfunction

    function automatic byte unsigned pick_gap();
        case ($urandom_range(0, 3))
            0: return tlj_pkg::CH_SPACE;
            1: return tlj_pkg::CH_TAB;
            2: return tlj_pkg::CH_CR;
            default: return tlj_pkg::CH_NEWLINE;
        endcase
    endfunction

    // random text of words; most words short, a few longer than any line
    task automatic send_text(input int unsigned words, input bit with_end);
        int unsigned len;
        bit last;
        if ($urandom_range(0, 4) == 0) begin
            send_byte(pick_gap(), 1'b0);
            rand_items++;
        end
        for (int n = 0; n < words; n++) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 25) : $urandom_range(1, 8);
            for (int i = 0; i < len; i++) begin
                last = with_end && n == words - 1 && i == len - 1 && $urandom_range(0, 1);
                send_byte(pick_letter(), last);
                rand_items++;
                if (last)
                    return;
            end
            repeat ($urandom_range(1, 2)) begin
                last = with_end && n == words - 1;
                send_byte(pick_gap(), last);
                rand_items++;
                if (last)
                    return;
            end
        end
    endtask

    task automatic send_word(input string s);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i], 1'b0);
    endtask

    initial
    begin
        sb = new();
        sb.hard_reset();
        calm = 1'b0;
        rand_items = 0;
        rst_n = 1'b0;
        text_valid = 1'b0;
        text_data = '0;
        char_ready = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reset width, extreme letters, every separator, long word, empty text
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(tlj_pkg::CH_SPACE, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'h7F, 1'b0);
        send_byte(tlj_pkg::CH_TAB, 1'b0);
        send_word("abcdefghijklmnopqrstuvw");
        send_byte(tlj_pkg::CH_CR, 1'b0);
        send_byte(tlj_pkg::CH_NEWLINE, 1'b1);
        send_byte(tlj_pkg::CH_SPACE, 1'b0);
        send_byte(tlj_pkg::CH_TAB, 1'b1);
        write_width(5'd0);
        send_word("ab c");
        send_byte(8'h64, 1'b1);

        // width phases, extremes included; clean stretch on one of them
        write_width(5'd31);
        calm = 1'b1;
        send_text(4, 1'b1);
        calm = 1'b0;
        write_width(5'd2);
        send_text(3, 1'b1);
        write_width(5'd7);
        send_text(2, 1'b0);
        // width changes while a text is still open
        write_width(5'd3);
        send_text(2, 1'b1);
        write_width(5'd1);
        send_text(3, 1'b1);
        while (rand_items < 110) begin
            write_width(tlj_pkg::CFG_W'($urandom_range(0, 31)));
            send_text($urandom_range(2, 4), 1'b1);
        end
        write_width(5'd20);
        send_text(2, 1'b1);

        drain();
        if (sb.fail_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // watchdog
    initial
    begin
        #5ms;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule
